### hdl/mctw_pkg.sv
// ============================================================================
// mctw_pkg
// Shared types, constants and helpers of the multi-channel task watchdog.
// ============================================================================
package mctw_pkg;

   localparam int CHANNELS = 8;
   localparam int TICK_MS  = 50;

   localparam int CH_W     = 4;
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int TICK_W   = 11;
   localparam int MS_W     = 16;
   localparam int CNT_W    = 16;

   localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
   localparam logic [CH_W:0]     CH_LIMIT = (CH_W+1)'(CHANNELS);
   localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

   // floor(ms / TICK_MS) as (ms * RECIP) >> RECIP_SHIFT, exact for ms * TICK_MS < 2**26
   localparam int          RECIP_SHIFT = 26;
   localparam int          RECIP_W     = RECIP_SHIFT + 1;
   localparam int          PROD_W      = MS_W + RECIP_W;
   localparam longint      RECIP_L     = ((64'd1 << RECIP_SHIFT) + TICK_MS - 1) / TICK_MS;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

   localparam int REQ_W      = 24;
   localparam int RSP_W      = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic CSR_FORCE   = 1'b0;
   localparam logic CSR_STARTUP = 1'b1;

   typedef enum logic [1:0] {
      CMD_ARM  = 2'd0,
      CMD_FEED = 2'd1,
      CMD_TICK = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      FAULT_NONE    = 2'd0,
      FAULT_EXPIRED = 2'd1,
      FAULT_UNARMED = 2'd2
   } fault_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HOLD
   } state_type;

   // token handed from cell to cell during a tick
   typedef struct packed {
      logic            active;
      logic            expired;
      logic            idle_seen;
      logic [CH_W-1:0] channel;
   } scan_type;

   // result beat, accepted in the lowest bit
   typedef struct packed {
      logic [CH_W-1:0] fault_channel;
      logic [1:0]      fault_kind;
      logic            reset_request;
      logic            feed_hardware;
      logic            accepted;
   } rsp_type;

   function automatic logic [TICK_W-1:0] ms_to_ticks(input logic [MS_W-1:0] ms);
      logic [PROD_W-1:0]             prod;
      logic [PROD_W-RECIP_SHIFT-1:0] quo;
      logic [TICK_W-1:0]             res;
      prod = PROD_W'(ms) * PROD_W'(RECIP);
      quo  = prod[PROD_W-1:RECIP_SHIFT];
      if (quo == '0) begin
         res = TICK_W'(1);
      end else if (quo > (PROD_W-RECIP_SHIFT)'(TICK_MAX)) begin
         res = TICK_MAX;
      end else begin
         res = quo[TICK_W-1:0];
      end
      return res;
   endfunction

endpackage

### hdl/multi_channel_task_watchdog.sv
// ============================================================================
// multi_channel_task_watchdog
// Bank of per-task software watchdog channels with startup supervision.
// ============================================================================
// Request beats on req_* carry cmd, channel and timeout_ms; each one gives
// exactly one response beat on rsp_*. Arm loads an idle channel with
// timeout_ms / TICK_MS ticks (at least 1, at most 2047); feed reloads a
// channel; tick counts running channels down, up to the first expiry,
// and reports feed_hardware, reset_request or a fault with its channel.
// One request is in work at a time. Arm, feed and unknown commands go from
// acceptance to the hold state and then into the output register. A tick
// walks a token down the row of CHANNELS cells, one cell per cycle, and
// then goes through the hold state; a tick while stopped or forced goes
// straight to the hold state. A new request is taken the cycle after the result
// moves into the output register, even if that register is still held.
// A stalled rsp_tready holds the output beat and, once the next result is
// finished, the request side too.
// Reset clears all channels to idle, the stop and startup state, and the
// registers to force_reboot = 0 and startup_ticks = 400.
// CSR: force_reboot at 0x0, startup_ticks at 0x4.
module multi_channel_task_watchdog (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mctw_pkg::REQ_W-1:0]          req_tdata,   // cmd, channel, timeout_ms
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mctw_pkg::RSP_W-1:0]          rsp_tdata,   // accepted, feed_hardware,
                                                            // reset_request, fault_kind,
                                                            // fault_channel
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mctw_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mctw_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mctw_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int N = mctw_pkg::CHANNELS;

   mctw_pkg::state_type            state_ff, state_in;
   logic                           force_ff, force_in;
   logic [mctw_pkg::CNT_W-1:0]     startup_ticks_ff, startup_ticks_in;
   logic [mctw_pkg::CNT_W-1:0]     startup_count_ff, startup_count_in;
   logic                           startup_done_ff, startup_done_in;
   logic                           stopped_ff, stopped_in;
   mctw_pkg::rsp_type              pend_ff, pend_in;
   mctw_pkg::rsp_type              rsp_ff, rsp_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic [1:0]                     req_cmd;
   logic [mctw_pkg::CH_W-1:0]      req_channel;
   logic [mctw_pkg::MS_W-1:0]      req_timeout_ms;
   logic                           accept;
   logic                           in_range;
   logic [mctw_pkg::CH_IDX_W-1:0]  ch_idx;
   logic                           sel_running;
   logic                           launch;
   logic                           out_free;
   logic                           csr_write;
   logic [mctw_pkg::TICK_W-1:0]    arm_ticks;

   logic [N-1:0]                   running_vec;
   logic [N-1:0]                   arm_vec;
   logic [N-1:0]                   feed_vec;
   logic [N-1:0]                   active_vec;
   mctw_pkg::scan_type             chain [N+1];
   mctw_pkg::scan_type             tail;

   assign req_cmd        = req_tdata[1:0];
   assign req_channel    = req_tdata[5:2];
   assign req_timeout_ms = req_tdata[21:6];

   assign req_tready  = (state_ff == mctw_pkg::ST_IDLE);
   assign accept      = req_tvalid && req_tready;
   assign in_range    = {1'b0, req_channel} < mctw_pkg::CH_LIMIT;
   assign ch_idx      = req_channel[mctw_pkg::CH_IDX_W-1:0];
   assign sel_running = running_vec[ch_idx];
   assign arm_ticks   = mctw_pkg::ms_to_ticks(req_timeout_ms);
   assign launch      = accept && (req_cmd == mctw_pkg::CMD_TICK) && !force_ff && !stopped_ff;
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign tail        = chain[N];

   assign chain[0] = '{active: launch, expired: 1'b0, idle_seen: 1'b0, channel: '0};

   for (genvar g = 0; g < N; g++) begin : g_cell
      assign arm_vec[g]  = accept && (req_cmd == mctw_pkg::CMD_ARM) && in_range
                           && !sel_running && (ch_idx == mctw_pkg::CH_IDX_W'(g));
      assign feed_vec[g] = accept && (req_cmd == mctw_pkg::CMD_FEED) && in_range
                           && (ch_idx == mctw_pkg::CH_IDX_W'(g));
      assign active_vec[g] = chain[g+1].active;

      mctw_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .cell_index   (mctw_pkg::CH_W'(g)),
         .arm          (arm_vec[g]),
         .feed         (feed_vec[g]),
         .reload_value (arm_ticks),
         .chain_in     (chain[g]),
         .running      (running_vec[g]),
         .chain_out    (chain[g+1])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mctw_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = launch ? mctw_pkg::ST_SCAN : mctw_pkg::ST_HOLD;
            end
         end
         mctw_pkg::ST_SCAN: begin
            if (tail.active) begin
               state_in = mctw_pkg::ST_HOLD;
            end
         end
         mctw_pkg::ST_HOLD: begin
            if (out_free) begin
               state_in = mctw_pkg::ST_IDLE;
            end
         end
         default: state_in = mctw_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      pend_in          = pend_ff;
      stopped_in       = stopped_ff;
      startup_count_in = startup_count_ff;
      startup_done_in  = startup_done_ff;
      rsp_in           = rsp_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;

      if (accept) begin
         pend_in = '0;
         case (req_cmd)
            mctw_pkg::CMD_ARM: begin
               pend_in.accepted = in_range && !sel_running;
            end
            mctw_pkg::CMD_TICK: begin
               if (force_ff || stopped_ff) begin
                  pend_in.reset_request = 1'b1;
               end else if (!startup_done_ff && startup_count_ff != mctw_pkg::CNT_MAX) begin
                  startup_count_in = startup_count_ff + mctw_pkg::CNT_W'(1);
               end
            end
            default: ;
         endcase
      end

      if (state_ff == mctw_pkg::ST_SCAN && tail.active) begin
         if (tail.expired) begin
            stopped_in            = 1'b1;
            pend_in.fault_kind    = mctw_pkg::FAULT_EXPIRED;
            pend_in.fault_channel = tail.channel;
         end else if (startup_count_ff < startup_ticks_ff || startup_done_ff) begin
            pend_in.feed_hardware = 1'b1;
         end else if (tail.idle_seen) begin
            stopped_in            = 1'b1;
            pend_in.fault_kind    = mctw_pkg::FAULT_UNARMED;
            pend_in.fault_channel = tail.channel;
         end else begin
            startup_done_in       = 1'b1;
            pend_in.feed_hardware = 1'b1;
         end
      end

      if (state_ff == mctw_pkg::ST_HOLD && out_free) begin
         rsp_in       = pend_ff;
         rsp_valid_in = 1'b1;
      end
   end

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      force_in         = force_ff;
      startup_ticks_in = startup_ticks_ff;
      csr_prdata       = '0;
      unique case (csr_paddr[2])
         mctw_pkg::CSR_FORCE: begin
            csr_prdata[0] = force_ff;
            if (csr_write) begin
               force_in = csr_pwdata[0];
            end
         end
         mctw_pkg::CSR_STARTUP: begin
            csr_prdata[mctw_pkg::CNT_W-1:0] = startup_ticks_ff;
            if (csr_write) begin
               startup_ticks_in = csr_pwdata[mctw_pkg::CNT_W-1:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= mctw_pkg::ST_IDLE;
         force_ff         <= 1'b0;
         startup_ticks_ff <= mctw_pkg::CNT_W'(400);
         startup_count_ff <= '0;
         startup_done_ff  <= 1'b0;
         stopped_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         force_ff         <= force_in;
         startup_ticks_ff <= startup_ticks_in;
         startup_count_ff <= startup_count_in;
         startup_done_ff  <= startup_done_in;
         stopped_ff       <= stopped_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(mctw_pkg::RSP_W - $bits(mctw_pkg::rsp_type)){1'b0}}, rsp_ff};

   // a stop latches until reset
   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("stop state cleared without reset");

   // startup supervision never reopens
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      startup_done_ff |=> startup_done_ff)
      else $error("startup_done cleared without reset");

   // at most one scan token in the row, and only while scanning
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(active_vec) && (active_vec == '0 || state_ff == mctw_pkg::ST_SCAN))
      else $error("scan token duplicated or stray");

   // a fault never feeds the hardware watchdog
   a_fault_no_feed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.fault_kind != mctw_pkg::FAULT_NONE |->
      !rsp_ff.feed_hardware && !rsp_ff.reset_request)
      else $error("fault reported together with feed or reset");

endmodule

### hdl/mctw_cell.sv
// ============================================================================
// mctw_cell
// One watchdog channel: reload and remaining tick counts, running flag, and
// one stage of the tick scan chain.
// ============================================================================
module mctw_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [mctw_pkg::CH_W-1:0]    cell_index,
   input  logic                         arm,
   input  logic                         feed,
   input  logic [mctw_pkg::TICK_W-1:0]  reload_value,
   input  mctw_pkg::scan_type           chain_in,
   output logic                         running,
   output mctw_pkg::scan_type           chain_out
);

   logic [mctw_pkg::TICK_W-1:0] reload_ff, reload_in;
   logic [mctw_pkg::TICK_W-1:0] remaining_ff, remaining_in;
   logic                        running_ff, running_in;
   mctw_pkg::scan_type          link_ff, link_in;
   logic [mctw_pkg::TICK_W-1:0] dec;

   always_comb begin
      reload_in    = reload_ff;
      remaining_in = remaining_ff;
      running_in   = running_ff;
      link_in      = chain_in;
      dec          = remaining_ff - mctw_pkg::TICK_W'(1);
      if (arm) begin
         reload_in    = reload_value;
         remaining_in = reload_value;
         running_in   = 1'b1;
      end else if (feed) begin
         remaining_in = reload_ff;
      end else if (chain_in.active && !chain_in.expired) begin
         if (running_ff) begin
            remaining_in = dec;
            if (dec == '0) begin
               link_in.expired = 1'b1;
               link_in.channel = cell_index;
            end
         end else if (!chain_in.idle_seen) begin
            link_in.idle_seen = 1'b1;
            link_in.channel   = cell_index;
         end
      end
   end

   always_ff @(posedge clock) begin
      reload_ff    <= reload_in;
      remaining_ff <= remaining_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         link_ff    <= '0;
      end else begin
         running_ff <= running_in;
         link_ff    <= link_in;
      end
   end

   assign running   = running_ff;
   assign chain_out = link_ff;

endmodule
